// ===== design/swpq_pkg.sv =====
// Shared types and constants for the sorted weight priority queue.
package swpq_pkg;

    localparam int WEIGHT_W = 32;
    localparam int SYMBOL_W = 8;
    localparam int TAG_W    = 16;
    localparam int ECOUNT_W = 7;
    localparam int OP_W     = 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

endpackage

// ===== design/swpq_controller.sv =====
// Sequencer for the queue: capture, scan and apply steps plus output valid.
module swpq_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output swpq_pkg::ctrl_cmd_t  cmd
);

    swpq_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= swpq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.scan    = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            swpq_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = swpq_pkg::ST_SCAN;
                end
            end
            swpq_pkg::ST_SCAN: begin
                cmd.scan   = 1'b1;
                state_next = swpq_pkg::ST_APPLY;
            end
            swpq_pkg::ST_APPLY: begin
                // hold until the output register is free
                cmd.commit = !out_valid_reg || m_tready;
                if (cmd.commit) begin
                    state_next = swpq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swpq_pkg::ST_IDLE;
            end
        endcase

        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== design/swpq_datapath.sv =====
// Row of queue cells with match flags, prefix scan, shift update and result register.
module swpq_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  swpq_pkg::ctrl_cmd_t            cmd,
    input  logic [swpq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [swpq_pkg::OP_W-1:0]      s_tuser,
    output logic [swpq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [swpq_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LV = $clog2(DEPTH);
    localparam int WW = swpq_pkg::WEIGHT_W;
    localparam int SW = swpq_pkg::SYMBOL_W;
    localparam int TW = swpq_pkg::TAG_W;
    localparam int EW = swpq_pkg::ECOUNT_W;

    // cell row, head at index 0
    logic [WW-1:0] weight_reg [DEPTH];
    logic [SW-1:0] symbol_reg [DEPTH];
    logic [TW-1:0] tag_reg    [DEPTH];
    logic [CW-1:0] count_reg, count_next;

    swpq_pkg::op_t op_reg;
    logic [WW-1:0] in_weight_reg;
    logic [SW-1:0] in_symbol_reg;
    logic [TW-1:0] in_tag_reg;

    logic [DEPTH-1:0] flag_next, flag_reg;
    logic [DEPTH-1:0] incl_reg, first_reg;
    logic [DEPTH-1:0] prefix [LV+1];

    logic [WW-1:0] in_weight;
    logic [SW-1:0] in_symbol;
    swpq_pkg::op_t in_op;

    logic [swpq_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_found_reg;

    assign in_weight = s_tdata[WW-1:0];
    assign in_symbol = s_tdata[WW+SW-1:WW];
    assign in_op     = swpq_pkg::op_t'(s_tuser);

    // per-cell match flags against the incoming item
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            case (in_op)
                swpq_pkg::OP_APPEND: flag_next[i] = (CW'(i) == count_reg);
                swpq_pkg::OP_INSERT: flag_next[i] = (CW'(i) == count_reg) ||
                    ((CW'(i) < count_reg) && (weight_reg[i] > in_weight));
                swpq_pkg::OP_POP:    flag_next[i] = (i == 0) && (count_reg != '0);
                swpq_pkg::OP_REMOVE: flag_next[i] = (CW'(i) < count_reg) &&
                    (symbol_reg[i] == in_symbol);
                default:             flag_next[i] = 1'b0;
            endcase
        end
    end

    // log-depth inclusive prefix OR of the flags
    always_comb begin
        prefix[0] = flag_reg;
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    prefix[l+1][i] = prefix[l][i] | prefix[l][i - (1 << l)];
                end else begin
                    prefix[l+1][i] = prefix[l][i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg        <= in_op;
            in_weight_reg <= in_weight;
            in_symbol_reg <= in_symbol;
            in_tag_reg    <= s_tdata[WW+SW+TW-1:WW+SW];
            flag_reg      <= flag_next;
        end
        if (cmd.scan) begin
            incl_reg  <= prefix[LV];
            first_reg <= flag_reg & ~{prefix[LV][DEPTH-2:0], 1'b0};
        end
    end

    // apply step: result fields and cell update
    logic          is_insert, full, found;
    logic [WW-1:0] sel_weight;
    logic [SW-1:0] sel_symbol;
    logic [TW-1:0] sel_tag;
    logic [CW+EW-1:0] count_wide;
    logic [EW-1:0]    entry_count;

    always_comb begin
        is_insert  = (op_reg == swpq_pkg::OP_APPEND) || (op_reg == swpq_pkg::OP_INSERT);
        full       = (count_reg == CW'(DEPTH));
        found      = !is_insert && (|first_reg);
        sel_weight = '0;
        sel_symbol = '0;
        sel_tag    = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_reg[i]) begin
                sel_weight = sel_weight | weight_reg[i];
                sel_symbol = sel_symbol | symbol_reg[i];
                sel_tag    = sel_tag | tag_reg[i];
            end
        end
        if (!found) begin
            sel_weight = '0;
            sel_symbol = '0;
            sel_tag    = '0;
        end
        if (is_insert && !full) begin
            count_next = count_reg + CW'(1);
        end else if (found) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end
        count_wide  = {{EW{1'b0}}, count_next};
        entry_count = count_wide[EW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (is_insert && !full) begin
                    if (first_reg[i]) begin
                        weight_reg[i] <= in_weight_reg;
                        symbol_reg[i] <= in_symbol_reg;
                        tag_reg[i]    <= in_tag_reg;
                    end else if (incl_reg[i] && i > 0) begin
                        // advance toward the tail
                        weight_reg[i] <= weight_reg[(i > 0) ? i - 1 : 0];
                        symbol_reg[i] <= symbol_reg[(i > 0) ? i - 1 : 0];
                        tag_reg[i]    <= tag_reg[(i > 0) ? i - 1 : 0];
                    end
                end else if (found && incl_reg[i] && i < DEPTH - 1) begin
                    // close the gap toward the head
                    weight_reg[i] <= weight_reg[(i < DEPTH - 1) ? i + 1 : i];
                    symbol_reg[i] <= symbol_reg[(i < DEPTH - 1) ? i + 1 : i];
                    tag_reg[i]    <= tag_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
            m_found_reg <= found;
            m_tdata_reg <= {7'd0,
                            is_insert && full,
                            count_next == CW'(1),
                            entry_count,
                            sel_symbol,
                            sel_weight,
                            sel_tag};
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_found_reg;

endmodule

// ===== design/sorted_weight_priority_queue_top.sv =====
// Top level of the sorted weight priority queue: controller plus cell datapath.
//
//  channel  | direction | tdata                                  | tuser
//  ---------+-----------+----------------------------------------+-------------
//  s_       | in        | weight[31:0] symbol[39:32] tag[55:40]  | op[1:0]
//  m_       | out       | out_tag, out_weight, out_symbol,       | found[0]
//           |           | entry_count, single_left, overflow     |
//
// Each item passes three steps: capture (match flags for every cell are
// registered at the accept edge), scan (log-depth prefix OR finds the first
// matching cell) and apply (the cell row shifts and the result is loaded).
// A new item is accepted only once the previous one has been applied; the apply
// step holds while a previous result still waits in the output register.
// aresetn (synchronous, active low) empties the queue; cell contents are left
// as they are and are never read at or above the count.
module sorted_weight_priority_queue_top #(
    parameter int DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // weight[31:0], symbol[39:32], tag[55:40]
    input  logic [swpq_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [swpq_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_tag[15:0], out_weight[47:16], out_symbol[55:48], entry_count[62:56],
    // single_left[63], overflow[64], zero fill[71:65]
    output logic [swpq_pkg::M_TDATA_W-1:0] m_tdata,
    // found[0]
    output logic [swpq_pkg::M_TUSER_W-1:0] m_tuser
);

    swpq_pkg::ctrl_cmd_t cmd;

    // sequence the three steps and own the output valid flag
    swpq_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // cell row, scan logic and result payload
    swpq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ===== tb/tb_sorted_weight_priority_queue_top.sv =====
// Testbench for the sorted weight priority queue: directed and random operations against a queue model.
module tb_sorted_weight_priority_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WEIGHT_W  = swpq_pkg::WEIGHT_W;
    localparam int SYMBOL_W  = swpq_pkg::SYMBOL_W;
    localparam int TAG_W     = swpq_pkg::TAG_W;
    localparam int ECOUNT_W  = swpq_pkg::ECOUNT_W;
    localparam int OP_W      = swpq_pkg::OP_W;
    localparam int S_TDATA_W = swpq_pkg::S_TDATA_W;
    localparam int M_TDATA_W = swpq_pkg::M_TDATA_W;
    localparam int M_TUSER_W = swpq_pkg::M_TUSER_W;

    localparam int QDEPTH         = 64;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side

    // One expected or observed result item.
    typedef struct packed {
        logic                found;
        logic [TAG_W-1:0]    out_tag;
        logic [WEIGHT_W-1:0] out_weight;
        logic [SYMBOL_W-1:0] out_symbol;
        logic [ECOUNT_W-1:0] entry_count;
        logic                single_left;
        logic                overflow;
    } queue_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Queue contents as the block should hold them; entry 0 is the head.
    logic [WEIGHT_W-1:0]  queue_weight [QDEPTH];
    logic [SYMBOL_W-1:0]  queue_symbol [QDEPTH];
    logic [TAG_W-1:0]     queue_tag    [QDEPTH];
    int                   queue_count;

    queue_result_t        pending_results [$];
    queue_result_t        want_result;
    queue_result_t        got_result;
    int unsigned          mismatch_count;
    int unsigned          send_idle_pct;
    int unsigned          recv_idle_pct;
    int unsigned          quiet_cycles;

    sorted_weight_priority_queue_top #(
        .DEPTH(QDEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one accepted operation to the queue copy and return the result it must produce.
    function automatic queue_result_t apply_queue_op(input swpq_pkg::op_t op,
                                                      input logic [WEIGHT_W-1:0] w,
                                                      input logic [SYMBOL_W-1:0] sym,
                                                      input logic [TAG_W-1:0] tg);
        queue_result_t res;
        int pos;
        int i;
        res = '0;
        if (op == swpq_pkg::OP_APPEND || op == swpq_pkg::OP_INSERT) begin
            if (queue_count >= QDEPTH) begin
                res.overflow = 1'b1;
            end else begin
                pos = queue_count;
                if (op == swpq_pkg::OP_INSERT) begin
                    // land in front of the first entry of greater weight, behind equal weights
                    pos = 0;
                    while (pos < queue_count && queue_weight[pos] <= w) pos++;
                end
                for (i = queue_count; i > pos; i--) begin
                    queue_weight[i] = queue_weight[i-1];
                    queue_symbol[i] = queue_symbol[i-1];
                    queue_tag[i]    = queue_tag[i-1];
                end
                queue_weight[pos] = w;
                queue_symbol[pos] = sym;
                queue_tag[pos]    = tg;
                queue_count++;
            end
        end else begin
            pos = queue_count;
            if (op == swpq_pkg::OP_POP) begin
                if (queue_count > 0) pos = 0;
            end else begin
                pos = 0;
                while (pos < queue_count && queue_symbol[pos] != sym) pos++;
            end
            if (pos < queue_count) begin
                res.found      = 1'b1;
                res.out_tag    = queue_tag[pos];
                res.out_weight = queue_weight[pos];
                res.out_symbol = queue_symbol[pos];
                for (i = pos; i + 1 < queue_count; i++) begin
                    queue_weight[i] = queue_weight[i+1];
                    queue_symbol[i] = queue_symbol[i+1];
                    queue_tag[i]    = queue_tag[i+1];
                end
                queue_count--;
            end
        end
        res.entry_count = queue_count[ECOUNT_W-1:0];
        res.single_left = (queue_count == 1);
        return res;
    endfunction

    // Send one item; call at a falling edge, returns at the falling edge after acceptance.
    task automatic send_item(input swpq_pkg::op_t op, input logic [WEIGHT_W-1:0] w,
                             input logic [SYMBOL_W-1:0] sym, input logic [TAG_W-1:0] tg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tg, sym, w};
        do
            @(posedge aclk);
        while (!s_tready);
        pending_results.push_back(apply_queue_op(op, w, sym, tg));
        @(negedge aclk);
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    // Pop and remove on an empty queue must report nothing found.
    task automatic test_empty_queue();
        send_item(swpq_pkg::OP_POP, '0, '0, '0);
        send_item(swpq_pkg::OP_REMOVE, '1, '1, '1);
    endtask

    // Extremes of the fields, stable ordering of equal weights, remove hit and miss.
    task automatic test_ordering();
        send_item(swpq_pkg::OP_APPEND, '1, 8'hFF, 16'hFFFF);
        send_item(swpq_pkg::OP_INSERT, '0, 8'h00, 16'h0000);
        send_item(swpq_pkg::OP_INSERT, 32'd5, 8'h01, 16'hA5A5);
        send_item(swpq_pkg::OP_INSERT, 32'd5, 8'h02, 16'h5A5A);
        send_item(swpq_pkg::OP_INSERT, 32'd5, 8'h03, 16'h0003);
        // append ignores order: smaller weight goes behind the largest
        send_item(swpq_pkg::OP_APPEND, 32'd1, 8'h04, 16'h0004);
        send_item(swpq_pkg::OP_INSERT, 32'h7FFF_FFFF, 8'h05, 16'h8000);
        wait_drained();
        send_item(swpq_pkg::OP_REMOVE, '0, 8'h02, '0);
        send_item(swpq_pkg::OP_REMOVE, '1, 8'h77, '1);
        send_item(swpq_pkg::OP_REMOVE, '0, 8'h04, '0);
        repeat (6) send_item(swpq_pkg::OP_POP, '1, '1, '1);
    endtask

    // Fill to capacity, check refusal for both insert kinds, then empty the queue.
    task automatic test_full_queue();
        int i;
        for (i = 0; i < QDEPTH; i++) begin
            send_item((i % 2 == 0) ? swpq_pkg::OP_INSERT : swpq_pkg::OP_APPEND,
                      WEIGHT_W'($urandom_range(3)), SYMBOL_W'(i), TAG_W'($urandom));
        end
        send_item(swpq_pkg::OP_APPEND, '0, 8'hEE, 16'h1234);
        send_item(swpq_pkg::OP_INSERT, '0, 8'hEF, 16'h4321);
        send_item(swpq_pkg::OP_REMOVE, '0, SYMBOL_W'(QDEPTH - 1), '0);
        send_item(swpq_pkg::OP_INSERT, '1, 8'hC3, 16'hFFFF);
        send_item(swpq_pkg::OP_INSERT, '1, 8'hC4, 16'h0000);
        for (i = 0; i <= QDEPTH; i++) send_item(swpq_pkg::OP_POP, '0, '0, '0);
        wait_drained();
    endtask

    // Random traffic in bursts that lean toward filling or toward emptying the queue.
    task automatic test_random_traffic(input int n_items, input int unsigned src_idle,
                                       input int unsigned sink_idle);
        int sent;
        int burst_left;
        bit growing;
        int unsigned pick;
        swpq_pkg::op_t op;
        logic [WEIGHT_W-1:0] w;
        logic [SYMBOL_W-1:0] sym;
        send_idle_pct = src_idle;
        recv_idle_pct = sink_idle;
        sent = 0;
        burst_left = 0;
        growing = 1'b1;
        while (sent < n_items) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(80, 10);
                growing = $urandom_range(1);
            end
            pick = $urandom_range(99);
            if ((growing && pick < 70) || (!growing && pick < 30))
                op = ($urandom_range(9) < 6) ? swpq_pkg::OP_INSERT : swpq_pkg::OP_APPEND;
            else
                op = ($urandom_range(1) == 1) ? swpq_pkg::OP_REMOVE : swpq_pkg::OP_POP;
            // small weights give plenty of ties for the stability check
            pick = $urandom_range(99);
            if (pick < 40)
                w = WEIGHT_W'($urandom_range(15));
            else if (pick < 50)
                w = pick[0] ? '1 : '0;
            else
                w = $urandom;
            // most removes target a symbol that is in the queue
            if (op == swpq_pkg::OP_REMOVE && queue_count > 0 && $urandom_range(3) != 0)
                sym = queue_symbol[$urandom_range(queue_count - 1)];
            else if ($urandom_range(1) == 1)
                sym = SYMBOL_W'($urandom_range(7));
            else
                sym = SYMBOL_W'($urandom);
            send_item(op, w, sym, TAG_W'($urandom));
            sent++;
            burst_left--;
        end
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: randomly stall, then compare each accepted item with the oldest expectation.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item arrived with no operation outstanding");
                mismatch_count++;
            end else begin
                want_result             = pending_results.pop_front();
                got_result.found        = m_tuser[0];
                got_result.out_tag      = m_tdata[15:0];
                got_result.out_weight   = m_tdata[47:16];
                got_result.out_symbol   = m_tdata[55:48];
                got_result.entry_count  = m_tdata[62:56];
                got_result.single_left  = m_tdata[63];
                got_result.overflow     = m_tdata[64];
                check_field("found", want_result.found, got_result.found);
                check_field("out_tag", want_result.out_tag, got_result.out_tag);
                check_field("out_weight", want_result.out_weight, got_result.out_weight);
                check_field("out_symbol", want_result.out_symbol, got_result.out_symbol);
                check_field("entry_count", want_result.entry_count, got_result.entry_count);
                check_field("single_left", want_result.single_left, got_result.single_left);
                check_field("overflow", want_result.overflow, got_result.overflow);
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = swpq_pkg::OP_APPEND;
        m_tready       = 1'b0;
        queue_count    = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 12;
        recv_idle_pct  = 50;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_queue();
        test_ordering();
        test_full_queue();
        test_random_traffic(420, 12, 50);
        test_random_traffic(420, 50, 12);
        test_random_traffic(420, 0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
